>>> rtl/longest_increasing_subsequence_length_core_defines.svh
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_CORE_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_CORE_DEFINES_SVH

// Checks that hold only while the block is out of reset.
`define LIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks that also hold during reset.
`define LIS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/lis_pkg.sv
`timescale 1ns / 1ps

package lis_pkg;

    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 7;

    // The length field saturates at the largest value its width can carry.
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};

    // Status a cell reports to its right-hand neighbour and to the top level.
    typedef struct packed {
        logic lt;  // cell holds a tail and that tail is below the incoming value
        logic ge;  // cell holds a tail and that tail is at or above the incoming value
    } lis_cell_status_t;

endpackage

>>> rtl/longest_increasing_subsequence_length_core.sv
`timescale 1ns / 1ps
// Streaming longest strictly increasing subsequence length.
// Input channel (s_valid/s_ready): one signed 32-bit element per transaction,
// with s_last marking the final element of a sequence.
// Result channel (m_valid/m_ready): one result per input transaction carrying the
// length so far (saturating at MAX_LEN), the element's last flag as m_is_final,
// and a sticky overflow flag set when an append found the table full.
// A row of MAX_LEN cells holds the tails; every cell compares the incoming value
// with its own tail in the same cycle and passes the outcome to its neighbour,
// so exactly one cell (or none when full) captures the value.
// The result is valid in the cycle after its input transaction. Throughput is one
// element per cycle unless the receiver stalls, set by the cell-row compare.
// The result sits in an output register; a new element is taken whenever that
// register is empty or being drained in the same cycle, so a stalled receiver
// holds the input side after one buffered result.
// Synchronous active-low reset clears the count, the overflow flag and the output
// valid; tail contents are not cleared and need no clearing pass. After an element
// with s_last set the count returns to zero, but the overflow flag remains.
`include "longest_increasing_subsequence_length_core_defines.svh"

module longest_increasing_subsequence_length_core #(
    parameter int MAX_LEN = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lis_pkg::VALUE_W-1:0]    s_value,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lis_pkg::LENGTH_W-1:0]          m_length,
    output logic                                  m_is_final,
    output logic                                  m_overflow
);
    import lis_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

    logic                     accept;
    logic [CNT_W-1:0]         count_reg, count_next, count_step;
    logic                     overflow_reg, overflow_next;
    logic                     m_valid_reg, m_valid_next;
    logic [LENGTH_W-1:0]      m_length_reg;
    logic                     m_is_final_reg;
    logic [LENGTH_W-1:0]      length_sat;
    logic [CMP_W-1:0]         count_wide;
    logic                     full;
    logic                     any_ge;

    lis_cell_status_t         status [MAX_LEN];
    logic [MAX_LEN-1:0]       occupied;
    logic [MAX_LEN-1:0]       ge_vec;
    logic [MAX_LEN-1:0]       wr_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
            logic prev_lt;
            if (gi == 0) begin : g_first
                assign prev_lt = 1'b1;
            end else begin : g_rest
                assign prev_lt = status[gi-1].lt;
            end

            assign occupied[gi] = CNT_W'(gi) < count_reg;
            assign ge_vec[gi]   = status[gi].ge;

            lis_cell u_cell (
                .aclk     (aclk),
                .load     (accept),
                .value    (s_value),
                .occupied (occupied[gi]),
                .prev_lt  (prev_lt),
                .status   (status[gi]),
                .write    (wr_vec[gi])
            );
        end
    endgenerate

    assign any_ge = |ge_vec;
    assign full   = count_reg == CNT_W'(MAX_LEN);

    always_comb begin
        count_step    = count_reg;
        overflow_next = overflow_reg;
        if (accept && !any_ge) begin
            if (full) begin
                overflow_next = 1'b1;
            end else begin
                count_step = count_reg + 1'b1;
            end
        end
        count_next = count_reg;
        if (accept) begin
            count_next = s_last ? '0 : count_step;
        end
    end

    always_comb begin
        count_wide = CMP_W'(count_step);
        if (count_wide > CMP_W'(LENGTH_MAX)) begin
            length_sat = LENGTH_MAX;
        end else begin
            length_sat = count_wide[LENGTH_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // The overflow flag travels with the result it was seen on.
    logic m_overflow_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_length_reg   <= length_sat;
            m_is_final_reg <= s_last;
            m_overflow_reg <= overflow_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_length   = m_length_reg;
    assign m_is_final = m_is_final_reg;
    assign m_overflow = m_overflow_reg;

    `LIS_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_LEN), "tail count above table depth")
    `LIS_ASSERT(a_single_write, $onehot0(wr_vec), "more than one cell captured a value")
    `LIS_ASSERT(a_last_clears, (accept && s_last) |=> (count_reg == '0), "count not cleared after last")
    `LIS_ASSERT(a_overflow_sticky, overflow_reg |=> overflow_reg, "overflow flag dropped")
    `LIS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!m_valid && count_reg == '0), "reset left state")

endmodule

>>> rtl/lis_cell.sv
`timescale 1ns / 1ps

module lis_cell (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic signed [lis_pkg::VALUE_W-1:0]    value,
    input  logic                                  occupied,
    input  logic                                  prev_lt,
    output lis_pkg::lis_cell_status_t             status,
    output logic                                  write
);
    import lis_pkg::*;

    logic signed [VALUE_W-1:0] tail_reg;
    logic                      below;

    assign below      = occupied && (tail_reg < value);
    assign status.lt  = below;
    assign status.ge  = occupied && !below;

    // Tails are sorted, so the only cell whose left neighbour is below the value
    // while it is not is either the first tail at or above it or the first free slot.
    assign write = load && prev_lt && !below;

    always_ff @(posedge aclk) begin
        if (write) begin
            tail_reg <= value;
        end
    end

endmodule
